>>> design/albs_pkg.sv
`default_nettype none

package albs_pkg;

  // Averaging window and sample path widths
  localparam int unsigned Window   = 10;
  localparam int unsigned SampleW  = 10;
  localparam int unsigned TotalW   = 14;
  localparam int unsigned PosW     = $clog2(Window);

  // Division of the window total by Window as a multiply by a scaled reciprocal
  localparam int unsigned AvgShift = 18;
  localparam int unsigned AvgRecip = (2 ** AvgShift + Window - 1) / Window;
  localparam int unsigned RecipW   = $clog2(AvgRecip + 1);
  localparam int unsigned ProdW    = TotalW + RecipW;

  // Offset, level and divider widths
  localparam int unsigned OffsetW  = 10;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned LevelW   = 12;
  localparam int unsigned DivdW    = LevelW - 1;
  localparam int unsigned DivSteps = DivdW;
  localparam int unsigned StepW    = $clog2(DivSteps);
  localparam int unsigned DutyW    = 8;
  localparam int unsigned DutyMax  = 255;

  // Configuration register indexes
  localparam logic [1:0] RegOffset   = 2'd0;
  localparam logic [1:0] RegScaling  = 2'd1;
  localparam logic [1:0] RegAllowOff = 2'd2;

  localparam logic [ScaleW-1:0] ScalingReset = 4'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic avg_en;
    logic prep;
    logic div_step;
    logic out_load;
  } albs_cmd_t;

endpackage

`default_nettype wire

>>> design/albs_ctrl.sv
`default_nettype none

module albs_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output albs_pkg::albs_cmd_t cmd_o
);
  import albs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.avg_en   = (state_q == ST_AVG);
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_AVG;
          end
        end
        ST_AVG: begin
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/albs_datapath.sv
`default_nettype none

module albs_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  albs_pkg::albs_cmd_t          cmd_i,
  input  wire [albs_pkg::SampleW-1:0]  sample_i,
  input  wire [albs_pkg::OffsetW-1:0]  offset_i,
  input  wire [albs_pkg::ScaleW-1:0]   scaling_i,
  input  wire                          allow_off_i,
  output logic [albs_pkg::DutyW-1:0]   brightness_o,
  output logic [albs_pkg::SampleW-1:0] smoothed_o
);
  import albs_pkg::*;

  logic [SampleW-1:0] ring_q [Window];
  logic [PosW-1:0]    pos_q;
  logic [TotalW-1:0]  total_q;
  logic [SampleW-1:0] avg_q;
  logic               neg_q;
  logic [DivdW-1:0]   dq_q;
  logic [ScaleW-1:0]  rem_q;
  logic [ScaleW-1:0]  div_q;
  logic [DutyW-1:0]   brightness_q;
  logic [SampleW-1:0] smoothed_q;

  logic [ProdW-1:0]   prod;
  logic [LevelW-1:0]  level;
  logic [ScaleW:0]    partial;
  logic               fits;
  logic [DutyW-1:0]   low_bound;
  logic [DutyW-1:0]   duty;

  // Average: total times reciprocal of the window, then shift
  assign prod = ProdW'(total_q) * ProdW'(AvgRecip);

  // Offset added to the average, sign extended
  assign level = {{(LevelW - SampleW){1'b0}}, avg_q}
               + {{(LevelW - OffsetW){offset_i[OffsetW-1]}}, offset_i};

  // One restoring divide step
  assign partial = {rem_q, dq_q[DivdW-1]};
  assign fits    = (partial >= {1'b0, div_q});

  // Clamp of the quotient to the duty range
  always_comb begin
    low_bound = allow_off_i ? '0 : DutyW'(1);
    if (neg_q) begin
      duty = low_bound;
    end else if (dq_q > DivdW'(DutyMax)) begin
      duty = DutyW'(DutyMax);
    end else if (dq_q[DutyW-1:0] < low_bound) begin
      duty = low_bound;
    end else begin
      duty = dq_q[DutyW-1:0];
    end
  end

  // Sample ring, position and running total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        ring_q[i] <= '0;
      end
      pos_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.accept) begin
      ring_q[pos_q] <= sample_i;
      total_q       <= total_q - TotalW'(ring_q[pos_q]) + TotalW'(sample_i);
      if (pos_q == PosW'(Window - 1)) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // Average, divider and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_en) begin
      avg_q <= prod[AvgShift +: SampleW];
    end
    if (cmd_i.prep) begin
      neg_q <= level[LevelW-1];
      dq_q  <= level[DivdW-1:0];
      rem_q <= '0;
      div_q <= (scaling_i == '0) ? ScaleW'(1) : scaling_i;
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? ScaleW'(partial - {1'b0, div_q}) : partial[ScaleW-1:0];
      dq_q  <= {dq_q[DivdW-2:0], fits};
    end
    if (cmd_i.out_load) begin
      brightness_q <= duty;
      smoothed_q   <= avg_q;
    end
  end

  assign brightness_o = brightness_q;
  assign smoothed_o   = smoothed_q;

endmodule

`default_nettype wire

>>> design/ambient_light_brightness_scaler_unit.sv
// Path to m_axis_tvalid: average, prep, divide steps, then output load.
// No new sample is taken until the 11-step restoring divider's result is loaded.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_ni low, asynchronous) clears the sample ring, ring position,
// running total and output valid, and returns the registers to their defaults.
`default_nettype none

module ambient_light_brightness_scaler_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  // s_axis_tdata: [9:0] sensor_sample, [15:10] zero
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,
  // m_axis_tdata: [7:0] brightness, [17:8] smoothed_level, [23:18] zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import albs_pkg::*;

  logic [OffsetW-1:0] offset_q;
  logic [ScaleW-1:0]  scaling_q;
  logic               allow_off_q;
  logic [1:0]         reg_idx;
  logic               wr_en;

  albs_cmd_t          cmd;
  logic [DutyW-1:0]   brightness;
  logic [SampleW-1:0] smoothed;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      scaling_q   <= ScalingReset;
      allow_off_q <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegOffset:   offset_q    <= pwdata[OffsetW-1:0];
        RegScaling:  scaling_q   <= pwdata[ScaleW-1:0];
        RegAllowOff: allow_off_q <= pwdata[0];
        default:     ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_idx)
      RegOffset:   prdata = 32'(offset_q);
      RegScaling:  prdata = 32'(scaling_q);
      RegAllowOff: prdata = 32'(allow_off_q);
      default:     prdata = '0;
    endcase
  end

  albs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  albs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_i     (s_axis_tdata[SampleW-1:0]),
    .offset_i     (offset_q),
    .scaling_i    (scaling_q),
    .allow_off_i  (allow_off_q),
    .brightness_o (brightness),
    .smoothed_o   (smoothed)
  );

  assign m_axis_tdata = {6'b0, smoothed, brightness};

endmodule

`default_nettype wire
